// ===== hw/rtl/tdpg_pkg.sv =====
// Package for the trial-division prime generator.
// Holds the default sizes, the limit reset value, the controller states and the
// command and status structs. It depends on nothing else.
`default_nettype none

package tdpg_pkg;

  localparam int MAX_PRIMES_DEF = 128;
  localparam int VALUE_BITS_DEF = 16;
  localparam int LIMIT_BITS     = 8;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_LOAD,
    ST_CHECK,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RES_RESTART,
    RES_DONE,
    RES_PRIME,
    RES_EXHAUST
  } res_kind_t;

  typedef struct packed {
    logic      ram_rd;
    logic      latch_div;
    logic      div_start;
    logic      idx_clear;
    logic      idx_inc;
    logic      cand_inc;
    logic      commit_prime;
    logic      do_restart;
    logic      set_exh;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic limit_hit;
    logic count_zero;
    logic last_index;
    logic root_passed;
    logic rem_done;
    logic rem_zero;
    logic cand_top;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tdpg_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the prime table; depends on nothing else.
`default_nettype none

module tdpg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tdpg_rem.sv =====
// Bit-serial remainder unit: one restoring step per cycle, VALUE_BITS steps.
// Only the zero test of the remainder is reported. Depends on nothing else.
`default_nettype none

module tdpg_rem #(
  parameter int VALUE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [VALUE_BITS-1:0] divisor,
  output logic                       done,
  output logic                       rem_zero
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] shreg;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;

  // The partial remainder stays below the divisor, so the shifted value fits
  // in one extra bit and the difference always fits back in VALUE_BITS.
  assign trial = {rem, shreg[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
    end else if (busy) begin
      shreg <= shreg << 1;
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[VALUE_BITS-1:0];
      end else begin
        rem <= trial[VALUE_BITS-1:0];
      end
    end
  end

  assign rem_zero = (rem == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/tdpg_datapath.sv =====
// Datapath of the prime generator: candidate, count, trial index, limit
// register, prime table, squaring stage, remainder unit and result register.
// Depends on tdpg_pkg, tdpg_ram and tdpg_rem.
`default_nettype none

module tdpg_datapath #(
  parameter int MAX_PRIMES = tdpg_pkg::MAX_PRIMES_DEF,
  parameter int VALUE_BITS = tdpg_pkg::VALUE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tdpg_pkg::cmd_t                     cmd,
  output tdpg_pkg::sts_t                          sts,
  input  wire logic                               cfg_we,
  input  wire logic [tdpg_pkg::LIMIT_BITS-1:0]    cfg_data,
  output logic      [VALUE_BITS-1:0]              res_value,
  output logic      [$clog2(MAX_PRIMES)-1:0]      res_index,
  output logic                                    res_done
);

  localparam int IW    = $clog2(MAX_PRIMES);
  localparam int CW    = $clog2(MAX_PRIMES + 1);
  localparam int CMP_W = (CW > tdpg_pkg::LIMIT_BITS) ? CW : tdpg_pkg::LIMIT_BITS;

  logic [tdpg_pkg::LIMIT_BITS-1:0] limit_q;
  logic [CW-1:0]                   count;
  logic [VALUE_BITS-1:0]           cand;
  logic                            exh;
  logic [IW-1:0]                   idx;
  logic [VALUE_BITS-1:0]           divr;
  logic [2*VALUE_BITS-1:0]         sq;
  logic [VALUE_BITS-1:0]           ram_rdata;
  logic [CMP_W-1:0]                lim_ext;
  logic [CMP_W-1:0]                lim_eff;
  logic                            cand_top;
  logic                            rem_done;
  logic                            rem_zero;

  assign cand_top = (cand == {VALUE_BITS{1'b1}});
  assign lim_ext  = CMP_W'(limit_q);
  assign lim_eff  = (lim_ext > CMP_W'(MAX_PRIMES)) ? CMP_W'(MAX_PRIMES) : lim_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_q <= tdpg_pkg::LIMIT_RESET;
      count   <= '0;
      cand    <= VALUE_BITS'(2);
      exh     <= 1'b0;
      idx     <= '0;
    end else begin
      if (cfg_we) begin
        limit_q <= cfg_data;
      end
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end
      if (cmd.do_restart) begin
        count <= '0;
        cand  <= VALUE_BITS'(2);
        exh   <= 1'b0;
      end else if (cmd.commit_prime) begin
        count <= count + CW'(1);
        if (cand_top) begin
          exh <= 1'b1;
        end else begin
          cand <= cand + VALUE_BITS'(1);
        end
      end else begin
        if (cmd.cand_inc) begin
          cand <= cand + VALUE_BITS'(1);
        end
        if (cmd.set_exh) begin
          exh <= 1'b1;
        end
      end
    end
  end

  tdpg_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_PRIMES)
  ) u_table (
    .clk  (clk),
    .we   (cmd.commit_prime),
    .waddr(count[IW-1:0]),
    .wdata(cand),
    .re   (cmd.ram_rd),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // Divisor and its square are registered together; the square bounds the
  // search at the root of the candidate.
  always_ff @(posedge clk) begin
    if (cmd.latch_div) begin
      divr <= ram_rdata;
      sq   <= ram_rdata * ram_rdata;
    end
  end

  tdpg_rem #(
    .VALUE_BITS(VALUE_BITS)
  ) u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(cand),
    .divisor (divr),
    .done    (rem_done),
    .rem_zero(rem_zero)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_kind)
        tdpg_pkg::RES_PRIME: begin
          res_value <= cand;
          res_index <= count[IW-1:0];
          res_done  <= 1'b0;
        end
        tdpg_pkg::RES_RESTART: begin
          res_value <= '0;
          res_index <= '0;
          res_done  <= 1'b0;
        end
        default: begin
          res_value <= '0;
          res_index <= '0;
          res_done  <= 1'b1;
        end
      endcase
    end
  end

  assign sts.limit_hit   = exh || (CMP_W'(count) >= lim_eff);
  assign sts.count_zero  = (count == '0);
  assign sts.last_index  = ((CW'(idx) + CW'(1)) == count);
  assign sts.root_passed = (sq > (2*VALUE_BITS)'(cand));
  assign sts.rem_done    = rem_done;
  assign sts.rem_zero    = rem_zero;
  assign sts.cand_top    = cand_top;

endmodule

`default_nettype wire

// ===== hw/rtl/tdpg_ctrl.sv =====
// Controller of the prime generator: the request state machine and the
// output valid flag. Depends on tdpg_pkg.
`default_nettype none

module tdpg_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           restart,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire tdpg_pkg::sts_t sts,
  output tdpg_pkg::cmd_t      cmd
);

  tdpg_pkg::state_t    state;
  tdpg_pkg::state_t    state_next;
  tdpg_pkg::res_kind_t kind;
  tdpg_pkg::res_kind_t kind_next;
  logic                out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tdpg_pkg::ST_IDLE;
      kind      <= tdpg_pkg::RES_DONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    unique case (state)
      tdpg_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (restart) begin
            kind_next  = tdpg_pkg::RES_RESTART;
            state_next = tdpg_pkg::ST_FINISH;
          end else if (sts.limit_hit) begin
            kind_next  = tdpg_pkg::RES_DONE;
            state_next = tdpg_pkg::ST_FINISH;
          end else if (sts.count_zero) begin
            kind_next  = tdpg_pkg::RES_PRIME;
            state_next = tdpg_pkg::ST_FINISH;
          end else begin
            state_next = tdpg_pkg::ST_LOOKUP;
          end
        end
      end
      tdpg_pkg::ST_LOOKUP: begin
        state_next = tdpg_pkg::ST_LOAD;
      end
      tdpg_pkg::ST_LOAD: begin
        state_next = tdpg_pkg::ST_CHECK;
      end
      tdpg_pkg::ST_CHECK: begin
        if (sts.root_passed) begin
          kind_next  = tdpg_pkg::RES_PRIME;
          state_next = tdpg_pkg::ST_FINISH;
        end else begin
          state_next = tdpg_pkg::ST_DIVIDE;
        end
      end
      tdpg_pkg::ST_DIVIDE: begin
        if (sts.rem_done) begin
          if (sts.rem_zero) begin
            if (sts.cand_top) begin
              kind_next  = tdpg_pkg::RES_EXHAUST;
              state_next = tdpg_pkg::ST_FINISH;
            end else begin
              state_next = tdpg_pkg::ST_LOOKUP;
            end
          end else if (sts.last_index) begin
            kind_next  = tdpg_pkg::RES_PRIME;
            state_next = tdpg_pkg::ST_FINISH;
          end else begin
            state_next = tdpg_pkg::ST_LOOKUP;
          end
        end
      end
      tdpg_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = tdpg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tdpg_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.res_kind = kind;
    in_ready     = 1'b0;
    unique case (state)
      tdpg_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.idx_clear = in_valid;
      end
      tdpg_pkg::ST_LOOKUP: begin
        cmd.ram_rd = 1'b1;
      end
      tdpg_pkg::ST_LOAD: begin
        cmd.latch_div = 1'b1;
      end
      tdpg_pkg::ST_CHECK: begin
        cmd.div_start = !sts.root_passed;
      end
      tdpg_pkg::ST_DIVIDE: begin
        if (sts.rem_done) begin
          if (sts.rem_zero) begin
            cmd.cand_inc  = !sts.cand_top;
            cmd.idx_clear = !sts.cand_top;
          end else begin
            cmd.idx_inc = !sts.last_index;
          end
        end
      end
      tdpg_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd.res_load     = 1'b1;
          cmd.do_restart   = (kind == tdpg_pkg::RES_RESTART);
          cmd.commit_prime = (kind == tdpg_pkg::RES_PRIME);
          cmd.set_exh      = (kind == tdpg_pkg::RES_EXHAUST);
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/trial_division_prime_generator_unit.sv =====
// Top level of the incremental trial-division prime generator.
// Joins the controller (tdpg_ctrl) and the datapath (tdpg_datapath); uses tdpg_pkg.
`default_nettype none

// Each beat on the input channel is one request. With restart high the
// block forgets every prime it holds, goes back to candidate 2 and returns a
// beat of zeros. With restart low it returns the next prime and its position
// in the sequence, or a beat with done_res high once prime_limit primes have
// been given (a limit above MAX_PRIMES counts as MAX_PRIMES) or the candidate
// range of VALUE_BITS bits has run out; that state holds until a restart.
// The block works on one request at a time. A request that needs no search
// (a restart, a done beat or the first prime) goes from idle straight to the
// finish state, which loads the result register once the output register is
// free, and the block then returns to idle to take the next request. In a
// search, each prime tried goes through a lookup state (the registered read
// of the prime table), a load state that registers the divisor and its
// square, a check state and, unless the square exceeds the candidate, a
// divide state in which the bit-serial remainder unit runs the trial
// division. The last candidate is passed as prime when the square of the
// next stored prime exceeds it or when no stored prime divides it. Only
// primes whose square does not exceed the candidate are tried, so the work
// per candidate grows with the square root of the candidate. A finished beat
// waits in the output register, and the next request is taken while it waits.
// The limit register may be written at any time the block is idle; the
// configuration channel is always ready.
module trial_division_prime_generator_unit #(
  parameter int MAX_PRIMES = tdpg_pkg::MAX_PRIMES_DEF,
  parameter int VALUE_BITS = tdpg_pkg::VALUE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            restart,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [VALUE_BITS-1:0]           prime_value,
  output logic      [$clog2(MAX_PRIMES)-1:0]   prime_index,
  output logic                                 done_res,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tdpg_pkg::LIMIT_BITS-1:0] prime_limit
);

  tdpg_pkg::cmd_t cmd;
  tdpg_pkg::sts_t sts;

  // The limit register is a plain register, so every configuration beat is
  // taken at once.
  assign cfg_ready = 1'b1;

  tdpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .restart  (restart),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the candidate, the count of primes found, the prime
  // table and the result register that drives the output fields.
  tdpg_datapath #(
    .MAX_PRIMES(MAX_PRIMES),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (prime_limit),
    .res_value(prime_value),
    .res_index(prime_index),
    .res_done (done_res)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tdpg_checker.sv =====
// Port-level checker for the prime generator, with its bind to the top level.
// Depends on tdpg_pkg and trial_division_prime_generator_unit.
`default_nettype none

module tdpg_checker #(
  parameter int MAX_PRIMES = tdpg_pkg::MAX_PRIMES_DEF,
  parameter int VALUE_BITS = tdpg_pkg::VALUE_BITS_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            restart,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [VALUE_BITS-1:0]           prime_value,
  input wire logic [$clog2(MAX_PRIMES)-1:0]   prime_index,
  input wire logic                            done_res,
  input wire logic                            cfg_valid,
  input wire logic                            cfg_ready,
  input wire logic [tdpg_pkg::LIMIT_BITS-1:0] prime_limit
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(prime_value)
      && $stable(prime_index) && $stable(done_res))
    else $error("result beat changed while stalled");

  // A done beat carries no prime.
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> prime_value == '0 && prime_index == '0)
    else $error("done beat carries a value");

  // The first prime of a sequence is 2; a restart beat is all zeros.
  a_first_two: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res && prime_index == '0 |->
      prime_value == VALUE_BITS'(2) || prime_value == '0)
    else $error("first prime is not 2");

  // Every prime after the first is odd and above 2.
  a_odd: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res && prime_index != '0 |->
      prime_value[0] && prime_value > VALUE_BITS'(2))
    else $error("later prime is even or too small");

endmodule

bind trial_division_prime_generator_unit tdpg_checker #(
  .MAX_PRIMES(MAX_PRIMES),
  .VALUE_BITS(VALUE_BITS)
) u_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for trial_division_prime_generator_unit.
// Drives requests and limit writes over valid/ready channels and checks every result beat
// against its own predictor of the prime sequence; needs only tdpg_pkg and the unit itself.
`default_nettype none

module tb_top;

  localparam int MAX_P = tdpg_pkg::MAX_PRIMES_DEF;
  localparam int VAL_W = tdpg_pkg::VALUE_BITS_DEF;
  localparam int LIM_W = tdpg_pkg::LIMIT_BITS;
  localparam int IDX_W = $clog2(MAX_P);
  localparam int unsigned TOP_VALUE = (1 << VAL_W) - 1;
  // This limit is meant to trip only on a hang.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned SETTLE_CYCLES = 300;

  // One result beat as the block presents it.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic             done;
  } prime_beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             restart = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [VAL_W-1:0] prime_value;
  logic [IDX_W-1:0] prime_index;
  logic             done_res;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LIM_W-1:0] prime_limit = '0;

  // Predictor state: the primes found since the last restart, how many there are, where the
  // search resumes, whether the candidate range has run out, and the limit register.
  logic [VAL_W-1:0] found_primes [MAX_P];
  int unsigned      found_total = 0;
  int unsigned      candidate_next = 2;
  bit               range_spent = 1'b0;
  logic [LIM_W-1:0] limit_setting = tdpg_pkg::LIMIT_RESET;

  // Beats that have been predicted but not yet seen on the output, oldest first.
  prime_beat_t awaited_beats [$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned requests_sent = 0;
  int unsigned restarts_sent = 0;
  int unsigned limit_writes = 0;
  int unsigned primes_seen = 0;
  int unsigned done_seen = 0;
  int unsigned largest_prime = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  trial_division_prime_generator_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .prime_value (prime_value),
    .prime_index (prime_index),
    .done_res    (done_res),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .prime_limit (prime_limit)
  );

  always #6 clk = ~clk;

  // Cycle count and watchdog. A hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d beats outstanding", cycle_count,
               awaited_beats.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver stalls at random; the percentage is changed by the test in progress.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Works out the beat that one accepted request must produce and advances the predictor.
  // A restart forgets the table; entries at or above found_total are never read, so their
  // stale contents do not matter. Every stored prime is tried as a divisor, which gives the
  // same answer as stopping at the square root.
  function automatic prime_beat_t next_prime_beat(input logic restart_req);
    prime_beat_t beat;
    int unsigned cap;
    int unsigned cand;
    bit          divisible;
    beat = '0;
    if (restart_req) begin
      found_total = 0;
      candidate_next = 2;
      range_spent = 1'b0;
      return beat;
    end
    // A limit larger than the table behaves as the table size.
    cap = (limit_setting > MAX_P) ? MAX_P : limit_setting;
    if (range_spent || found_total >= cap) begin
      beat.done = 1'b1;
      return beat;
    end
    for (cand = candidate_next; cand <= TOP_VALUE; cand++) begin
      divisible = 1'b0;
      for (int i = 0; i < found_total; i++) begin
        if (cand % found_primes[i] == 0) begin
          divisible = 1'b1;
          break;
        end
      end
      if (!divisible) begin
        found_primes[found_total] = cand[VAL_W-1:0];
        beat.value = cand[VAL_W-1:0];
        beat.index = found_total[IDX_W-1:0];
        found_total++;
        if (cand == TOP_VALUE) begin
          range_spent = 1'b1;
        end else begin
          candidate_next = cand + 1;
        end
        return beat;
      end
    end
    // The candidate range ran out without a prime. With a 128-entry table the search never
    // climbs that far, so this path is kept for completeness only.
    range_spent = 1'b1;
    beat.done = 1'b1;
    return beat;
  endfunction

  // Counts a mismatch and prints one line for it.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("Mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Result checker. Every accepted output beat is compared, field by field, with the oldest
  // prediction; a beat that arrives with nothing predicted is a failure in itself.
  always @(posedge clk) begin
    prime_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat value=%0d index=%0d done=%0b",
                                  prime_value, prime_index, done_res));
      end else begin
        want = awaited_beats.pop_front();
        if (prime_value !== want.value) begin
          report_mismatch($sformatf("prime_value %0d, expected %0d", prime_value, want.value));
        end
        if (prime_index !== want.index) begin
          report_mismatch($sformatf("prime_index %0d, expected %0d", prime_index, want.index));
        end
        if (done_res !== want.done) begin
          report_mismatch($sformatf("done_res %0b, expected %0b", done_res, want.done));
        end
        if (want.done) begin
          done_seen++;
        end else if (want.value != 0) begin
          primes_seen++;
          if (want.value > largest_prime) begin
            largest_prime = want.value;
          end
        end
      end
    end
  end

  // Sends one request beat. The sender may idle for some cycles first; once valid is raised
  // it stays up with the same payload until the block takes the beat, and the expected
  // result is predicted at the edge of acceptance.
  task automatic send_request(input logic restart_req);
    prime_beat_t beat;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart <= restart_req;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    beat = next_prime_beat(restart_req);
    awaited_beats.push_back(beat);
    requests_sent++;
    if (restart_req) begin
      restarts_sent++;
    end
  endtask

  // Holds the sender off until every predicted beat has come back. Valid is lowered and the
  // clock edge awaited before the queue is checked, so a following beat never raises it again in the same step.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_beats.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes the limit register. The block is drained first so that the write lands while it
  // is idle, and the predictor takes the new value at the same edge.
  task automatic write_limit(input logic [LIM_W-1:0] new_limit);
    wait_for_results();
    cfg_valid <= 1'b1;
    prime_limit <= new_limit;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    limit_setting = new_limit;
    limit_writes++;
  endtask

  // Straight out of reset, with the limit at its reset value: the first primes in order,
  // then a restart in the middle of the sequence, after which the count starts again at 0.
  task automatic test_opening_primes();
    repeat (6) send_request(1'b0);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
  endtask

  // Extremes of the limit register. A limit of one gives a single prime and then done
  // beats; a limit of zero gives done at once, also straight after a restart; the largest
  // value acts as the table size and must still hand out primes.
  task automatic test_limit_extremes();
    write_limit(8'd1);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    write_limit(8'd0);
    repeat (2) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    write_limit(8'hFF);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
  endtask

  // Random traffic under one idling pattern. Each phase picks a limit, then runs a few
  // sequences that open with a restart. Most sequences ask for the full run of primes and
  // a few more, so the done state is reached and held; others stop part way, and a share
  // are noise with restarts scattered through them. Now and then the sender holds off
  // until the block has drained.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int unsigned n_items);
    int unsigned target;
    int unsigned cap;
    int unsigned run_len;
    int          pick;
    int          shape;
    logic [LIM_W-1:0] new_limit;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = requests_sent + n_items;
    while (requests_sent < target) begin
      // Small limits keep the searches short; the table size and above come up often enough
      // to fill the table completely several times in a run.
      pick = $urandom_range(99);
      if (pick < 6) begin
        new_limit = 8'd0;
      end else if (pick < 16) begin
        new_limit = 8'hFF;
      end else if (pick < 22) begin
        new_limit = LIM_W'(MAX_P);
      end else if (pick < 27) begin
        new_limit = LIM_W'($urandom_range(MAX_P + 1, 254));
      end else if (pick < 32) begin
        new_limit = 8'd1;
      end else if (pick < 45) begin
        new_limit = LIM_W'($urandom_range(41, MAX_P - 1));
      end else begin
        new_limit = LIM_W'($urandom_range(2, 40));
      end
      write_limit(new_limit);
      cap = (limit_setting > MAX_P) ? MAX_P : limit_setting;
      repeat ($urandom_range(1, 3)) begin
        if (requests_sent < target) begin
          send_request(1'b1);
          shape = $urandom_range(99);
          if (shape < 60) begin
            run_len = cap + $urandom_range(0, 3);
          end else if (shape < 85) begin
            run_len = $urandom_range(0, cap);
          end else begin
            run_len = $urandom_range(4, 20);
          end
          for (int i = 0; i < run_len && requests_sent < target; i++) begin
            send_request(shape >= 85 && $urandom_range(9) == 0);
            if ($urandom_range(299) == 0) begin
              wait_for_results();
            end
          end
        end
      end
    end
  endtask

  // Test sequence: reset, the directed checks with no idling, then random traffic with the
  // receiver idling more than the sender, the other way round, and with neither idling. The
  // end waits for every beat, lets the block settle so that a stray beat would still be
  // caught, and then gives the verdict.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_opening_primes();
    test_limit_extremes();
    test_random_traffic(33, 78, 540);
    test_random_traffic(78, 33, 540);
    test_random_traffic(0, 0, 540);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d restarts) over %0d limit settings in %0d cycles.",
             requests_sent, restarts_sent, limit_writes, cycle_count);
    $display("Checked %0d primes up to %0d and %0d done beats; %0d mismatches.",
             primes_seen, largest_prime, done_seen, mismatch_count);
    if (mismatch_count == 0 && awaited_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/tdpg_pkg.sv
hw/rtl/tdpg_ram.sv
hw/rtl/tdpg_rem.sv
hw/rtl/tdpg_datapath.sv
hw/rtl/tdpg_ctrl.sv
hw/rtl/trial_division_prime_generator_unit.sv
hw/rtl/tdpg_checker.sv
verif/tb_top.sv
